// File: src/hkrb_pkg.sv
// Package: constants, state encoding and code classification for the keyboard report builder
`timescale 1ns / 1ps
`default_nettype none
package hkrb_pkg;

  localparam int KEY_SLOTS   = 6;
  localparam int SLOT_IDX_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int SLOTS_W     = 8 * KEY_SLOTS;
  localparam int FRAME_W     = 15;
  localparam int TIME_W      = 17;
  localparam int DELTA_W     = 18;
  localparam int WRAP_TOP    = 32767;
  localparam int DELTA_CLAMP = 5000;

  localparam logic [7:0] CODE_KEY_LO = 8'h04;
  localparam logic [7:0] CODE_KEY_HI = 8'hA4;
  localparam logic [7:0] CODE_MOD_LO = 8'hE0;
  localparam logic [7:0] CODE_MOD_HI = 8'hE7;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADD,
    ST_TIME,
    ST_WRAP,
    ST_POLL,
    ST_OUT
  } state_t;

  function automatic logic is_key_code(input logic [7:0] code);
    is_key_code = (code >= CODE_KEY_LO) && (code <= CODE_KEY_HI);
  endfunction

  function automatic logic is_mod_code(input logic [7:0] code);
    is_mod_code = (code >= CODE_MOD_LO) && (code <= CODE_MOD_HI);
  endfunction

endpackage
`default_nettype wire

// File: src/hid_keyboard_report_builder.sv
// Top level: six-key boot keyboard report keeper with a sequenced slot scanner and poll timer
//
//   channel | ports                                                 | handshake
//   --------+-------------------------------------------------------+-----------
//   input   | in_cmd in_pressed in_keycode in_frame_count            | valid/ready
//           | in_in_busy in_link_ready                               |
//   result  | out_send out_modifiers out_key_slots                   | valid/ready
//   config  | cfg_wr_data (idle rate)                                | cfg_wr_en
//
// A normal key scans the slots one slot per cycle through the shared byte comparator,
// then goes to the result (release) or first inserts into a free slot (press). A poll
// with the link up scans the slots, then does subtract, wrap fix and decision on the timer
// adder. Modifiers, ignored codes and polls with the link down go straight to the result.
// Reset (rst_n low, synchronous) empties the report, the sent copy and the timer.
// A result not taken holds the sequencer in its last state until out_ready.
`timescale 1ns / 1ps
`default_nettype none
module hid_keyboard_report_builder (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [7:0]                   cfg_wr_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_cmd,
  input  wire logic                         in_pressed,
  input  wire logic [7:0]                   in_keycode,
  input  wire logic [hkrb_pkg::FRAME_W-1:0] in_frame_count,
  input  wire logic                         in_in_busy,
  input  wire logic                         in_link_ready,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_send,
  output logic [7:0]                        out_modifiers,
  output logic [hkrb_pkg::SLOTS_W-1:0]      out_key_slots
);

  hkrb_pkg::state_t state_r, state_nxt;

  logic [7:0] idle_rate_r;
  logic [7:0] mod_r, mod_nxt;
  logic [7:0] sent_mod_r, sent_mod_nxt;
  logic [7:0] slot_r      [hkrb_pkg::KEY_SLOTS];
  logic [7:0] slot_nxt    [hkrb_pkg::KEY_SLOTS];
  logic [7:0] sent_slot_r [hkrb_pkg::KEY_SLOTS];
  logic [7:0] sent_slot_nxt [hkrb_pkg::KEY_SLOTS];
  logic signed [hkrb_pkg::TIME_W-1:0]  last_r, last_nxt;
  logic signed [hkrb_pkg::DELTA_W-1:0] delta_r, delta_nxt;

  logic                            cmd_r, pressed_r, busy_r;
  logic [7:0]                      code_r;
  logic [hkrb_pkg::FRAME_W-1:0]    now_r;
  logic [hkrb_pkg::SLOT_IDX_W-1:0] idx_r, idx_nxt;
  logic [hkrb_pkg::SLOT_IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic                            free_vld_r, free_vld_nxt;
  logic                            found_r, found_nxt;
  logic                            diff_r, diff_nxt;
  logic                            send_r, send_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_send_r;
  logic [7:0]                      out_mod_r;
  logic [hkrb_pkg::SLOTS_W-1:0]    out_slots_r;
  logic                            out_load;

  logic [7:0]                          cmp_a, cmp_b;
  logic                                cmp_eq;
  logic                                last_slot;
  logic signed [hkrb_pkg::DELTA_W-1:0] now_ext, last_ext;
  logic                                in_acc;
  logic [hkrb_pkg::SLOTS_W-1:0]        slots_packed;
  logic                                go;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == hkrb_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_send  = out_send_r;
  assign out_modifiers = out_mod_r;
  assign out_key_slots = out_slots_r;

  // shared byte comparator: slot against key code, or against the sent copy on a poll
  assign cmp_a     = slot_r[idx_r];
  assign cmp_b     = (cmd_r == hkrb_pkg::CMD_POLL) ? sent_slot_r[idx_r] : code_r;
  assign cmp_eq    = (cmp_a == cmp_b);
  assign last_slot = (idx_r == hkrb_pkg::SLOT_IDX_W'(hkrb_pkg::KEY_SLOTS - 1));

  assign now_ext  = $signed({{(hkrb_pkg::DELTA_W - hkrb_pkg::FRAME_W){1'b0}}, now_r});
  assign last_ext = $signed({last_r[hkrb_pkg::TIME_W-1], last_r});

  always_comb begin
    slots_packed = '0;
    for (int i = 0; i < hkrb_pkg::KEY_SLOTS; i++) begin
      slots_packed[8*i +: 8] = slot_r[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    sent_mod_nxt  = sent_mod_r;
    slot_nxt      = slot_r;
    sent_slot_nxt = sent_slot_r;
    last_nxt      = last_r;
    delta_nxt     = delta_r;
    idx_nxt       = idx_r;
    free_idx_nxt  = free_idx_r;
    free_vld_nxt  = free_vld_r;
    found_nxt     = found_r;
    diff_nxt      = diff_r;
    send_nxt      = send_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    go            = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      hkrb_pkg::ST_IDLE: begin
        if (in_acc) begin
          idx_nxt      = '0;
          free_vld_nxt = 1'b0;
          found_nxt    = 1'b0;
          diff_nxt     = 1'b0;
          send_nxt     = 1'b0;
          if (in_cmd == hkrb_pkg::CMD_KEY) begin
            if (hkrb_pkg::is_key_code(in_keycode)) begin
              state_nxt = hkrb_pkg::ST_SCAN;
            end else begin
              if (hkrb_pkg::is_mod_code(in_keycode)) begin
                if (in_pressed) begin
                  mod_nxt = mod_r | (8'd1 << in_keycode[2:0]);
                end else begin
                  mod_nxt = mod_r & ~(8'd1 << in_keycode[2:0]);
                end
              end
              state_nxt = hkrb_pkg::ST_OUT;
            end
          end else begin
            state_nxt = in_link_ready ? hkrb_pkg::ST_SCAN : hkrb_pkg::ST_OUT;
          end
        end
      end
      hkrb_pkg::ST_SCAN: begin
        if (cmd_r == hkrb_pkg::CMD_POLL) begin
          if (!cmp_eq) begin
            diff_nxt = 1'b1;
          end
        end else begin
          if (cmp_eq) begin
            found_nxt = 1'b1;
            // release empties every matching slot
            if (!pressed_r) begin
              slot_nxt[idx_r] = '0;
            end
          end
          if (cmp_a == 8'd0 && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = idx_r;
          end
        end
        if (last_slot) begin
          if (cmd_r == hkrb_pkg::CMD_POLL) begin
            state_nxt = hkrb_pkg::ST_TIME;
          end else begin
            state_nxt = pressed_r ? hkrb_pkg::ST_ADD : hkrb_pkg::ST_OUT;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      hkrb_pkg::ST_ADD: begin
        // drop a press already present or with no free slot
        if (!found_r && free_vld_r) begin
          slot_nxt[free_idx_r] = code_r;
        end
        state_nxt = hkrb_pkg::ST_OUT;
      end
      hkrb_pkg::ST_TIME: begin
        delta_nxt = now_ext - last_ext;
        state_nxt = hkrb_pkg::ST_WRAP;
      end
      hkrb_pkg::ST_WRAP: begin
        // frame counter wrapped past its top
        if (delta_r < 0) begin
          delta_nxt = hkrb_pkg::DELTA_W'(hkrb_pkg::WRAP_TOP) - last_ext + now_ext;
        end
        state_nxt = hkrb_pkg::ST_POLL;
      end
      hkrb_pkg::ST_POLL: begin
        if (delta_r > $signed(hkrb_pkg::DELTA_W'(hkrb_pkg::DELTA_CLAMP))) begin
          last_nxt = hkrb_pkg::TIME_W'(now_ext
                     - $signed(hkrb_pkg::DELTA_W'(hkrb_pkg::DELTA_CLAMP)));
        end
        if (!busy_r) begin
          go = diff_r || (mod_r != sent_mod_r) ||
               ((idle_rate_r != 8'd0) &&
                (delta_r >= $signed({{(hkrb_pkg::DELTA_W - 8){1'b0}}, idle_rate_r})));
          if (go) begin
            sent_mod_nxt  = mod_r;
            sent_slot_nxt = slot_r;
            last_nxt      = hkrb_pkg::TIME_W'(now_ext);
          end
        end
        send_nxt  = go;
        state_nxt = hkrb_pkg::ST_OUT;
      end
      hkrb_pkg::ST_OUT: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = hkrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hkrb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hkrb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      idle_rate_r <= '0;
      mod_r       <= '0;
      sent_mod_r  <= '0;
      last_r      <= '0;
      for (int i = 0; i < hkrb_pkg::KEY_SLOTS; i++) begin
        slot_r[i]      <= '0;
        sent_slot_r[i] <= '0;
      end
      idx_r      <= '0;
      free_vld_r <= 1'b0;
      found_r    <= 1'b0;
      diff_r     <= 1'b0;
      send_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        idle_rate_r <= cfg_wr_data;
      end
      mod_r       <= mod_nxt;
      sent_mod_r  <= sent_mod_nxt;
      last_r      <= last_nxt;
      slot_r      <= slot_nxt;
      sent_slot_r <= sent_slot_nxt;
      idx_r       <= idx_nxt;
      free_vld_r  <= free_vld_nxt;
      found_r     <= found_nxt;
      diff_r      <= diff_nxt;
      send_r      <= send_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= in_cmd;
      pressed_r <= in_pressed;
      code_r    <= in_keycode;
      now_r     <= in_frame_count;
      busy_r    <= in_in_busy;
    end
    free_idx_r <= free_idx_nxt;
    delta_r    <= delta_nxt;
    if (out_load) begin
      out_send_r  <= send_r;
      out_mod_r   <= mod_r;
      out_slots_r <= slots_packed;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("sequencer still idle after an accepted item");

  a_add_only_on_press: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hkrb_pkg::ST_ADD |-> (cmd_r == hkrb_pkg::CMD_KEY) && pressed_r)
    else $error("slot insert reached without a key press");

  a_sent_copy_only_on_poll: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != hkrb_pkg::ST_POLL |=> $stable(sent_mod_r) && $stable(last_r))
    else $error("sent report or timer changed outside the poll decision");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= hkrb_pkg::SLOT_IDX_W'(hkrb_pkg::KEY_SLOTS - 1))
    else $error("slot index beyond the last slot");

  a_key_never_sends: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && (cmd_r == hkrb_pkg::CMD_KEY) |-> !send_r)
    else $error("key event flagged a send");

endmodule
`default_nettype wire
